FILE: rtl/core/cpualu_pkg.sv
// Shared types and constants for the 8-bit handheld CPU ALU.
`timescale 1ns / 1ps

package cpualu_pkg;

    // Field widths
    localparam int OP_W   = 5;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;

    // Request and result bus widths (fields packed from bit 0, padded to bytes)
    localparam int IN_BITS   = OP_W + BYTE_W + BYTE_W + WORD_W;
    localparam int OUT_BITS  = BYTE_W + BYTE_W + WORD_W + 4;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_ADD16 = 5'd2,
        OP_SUB   = 5'd3,
        OP_SBC   = 5'd4,
        OP_INC   = 5'd5,
        OP_DEC   = 5'd6,
        OP_AND   = 5'd7,
        OP_OR    = 5'd8,
        OP_XOR   = 5'd9,
        OP_CP    = 5'd10,
        OP_SWAP  = 5'd11,
        OP_RLC   = 5'd12,
        OP_RL    = 5'd13,
        OP_RRC   = 5'd14,
        OP_RR    = 5'd15,
        OP_SLA   = 5'd16,
        OP_SRA   = 5'd17,
        OP_SRL   = 5'd18,
        OP_DAA   = 5'd19
    } alu_op_t;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } alu_flags_t;

    // Architectural state kept between requests
    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [WORD_W-1:0] hl;
        alu_flags_t        flags;
    } alu_state_t;

endpackage

FILE: rtl/core/cpu_alu_with_flags.sv
// Top level of the 8-bit handheld CPU ALU with accumulator, HL and flags.
//
// Usage:
//   Requests arrive on the s_ stream: each names an operation and carries an
//   8-bit operand, a register value and a 16-bit word. The block applies the
//   operation to its accumulator, HL pair and Z/N/H/C flags (or to the given
//   register value) and returns one result on the m_ stream: the new register
//   value, accumulator, HL and the four flags.
//   The result is registered and valid in the cycle after the request is accepted.
//   Throughput: one request per cycle unless m_tready stalls. The state update and result for a
//   request are computed in the accept cycle by the execute logic, so the
//   next request sees the updated accumulator, HL and flags at once.
//   Reset: accumulator, HL and flags clear to zero; the result register
//   is emptied.
//   Stall: while a result waits and m_tready is low, s_tready drops and the
//   state holds; a result taken in the same cycle frees room for a new one.
`timescale 1ns / 1ps

module cpu_alu_with_flags (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[4:0], operand_byte[12:5], register_value[20:13],
    // operand_word[36:21], zero pad[39:37]
    input  logic [cpualu_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // register_result[7:0], accumulator[15:8], hl_pair[31:16], flag_zero[32],
    // flag_subtract[33], flag_half[34], flag_carry[35], zero pad[39:36]
    output logic [cpualu_pkg::OUT_DATA_W-1:0] m_tdata
);

    import cpualu_pkg::*;

    alu_state_t        state_reg;
    alu_state_t        state_next;
    logic [BYTE_W-1:0] rres_next;
    logic [BYTE_W-1:0] rres_reg;
    logic              m_tvalid_reg;
    logic              accept;

    // Request fields
    logic [OP_W-1:0]   in_op;
    logic [BYTE_W-1:0] in_byte;
    logic [BYTE_W-1:0] in_reg;
    logic [WORD_W-1:0] in_word;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_byte = s_tdata[OP_W +: BYTE_W];
    assign in_reg  = s_tdata[OP_W+BYTE_W +: BYTE_W];
    assign in_word = s_tdata[OP_W+2*BYTE_W +: WORD_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    cpualu_exec u_exec (
        .operation       (in_op),
        .operand_byte    (in_byte),
        .register_value  (in_reg),
        .operand_word    (in_word),
        .state           (state_reg),
        .state_next      (state_next),
        .register_result (rres_next)
    );

    // Architectural state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            rres_reg <= rres_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                       state_reg.flags.c, state_reg.flags.h,
                       state_reg.flags.n, state_reg.flags.z,
                       state_reg.hl, state_reg.acc, rres_reg};

endmodule

FILE: rtl/core/cpualu_exec.sv
// Combinational execute logic: one operation applied to the current state.
`timescale 1ns / 1ps

module cpualu_exec (
    input  logic [cpualu_pkg::OP_W-1:0]   operation,
    input  logic [cpualu_pkg::BYTE_W-1:0] operand_byte,
    input  logic [cpualu_pkg::BYTE_W-1:0] register_value,
    input  logic [cpualu_pkg::WORD_W-1:0] operand_word,
    input  cpualu_pkg::alu_state_t        state,
    output cpualu_pkg::alu_state_t        state_next,
    output logic [cpualu_pkg::BYTE_W-1:0] register_result
);

    import cpualu_pkg::*;

    alu_op_t     op;
    logic        cin;
    logic        use_cin;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [16:0] w_sum;
    logic [12:0] w_half;
    logic [7:0]  a;
    logic [7:0]  r;
    logic [7:0]  rres;
    logic        daa_c;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_res;

    assign op  = alu_op_t'(operation);
    assign a   = state.acc;
    assign r   = register_value;
    assign cin = state.flags.c;
    assign use_cin = cin & ((op == OP_ADC) || (op == OP_SBC));

    // Shared adders
    assign add_sum  = {1'b0, a} + {1'b0, operand_byte} + {8'd0, use_cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, operand_byte[3:0]} + {4'd0, use_cin};
    assign sub_diff = {1'b0, a} - {1'b0, operand_byte} - {8'd0, use_cin};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, operand_byte[3:0]} - {4'd0, use_cin};
    assign w_sum    = {1'b0, state.hl} + {1'b0, operand_word};
    assign w_half   = {1'b0, state.hl[11:0]} + {1'b0, operand_word[11:0]};

    // Decimal adjust
    always_comb
    begin
        daa_c   = cin;
        daa_adj = 8'd0;
        if (!state.flags.n)
        begin
            if (cin || (a > DAA_HI_LIM))
            begin
                daa_c   = 1'b1;
                daa_adj = DAA_HI_ADJ;
            end
            if (state.flags.h || (a[3:0] > DAA_LO_LIM))
                daa_adj = daa_adj + DAA_LO_ADJ;
            daa_res = a + daa_adj;
        end
        else
        begin
            if (cin)
                daa_adj = DAA_HI_ADJ;
            if (state.flags.h)
                daa_adj = daa_adj + DAA_LO_ADJ;
            daa_res = a - daa_adj;
        end
    end

    // Operation select
    always_comb
    begin
        state_next = state;
        rres       = 8'd0;
        case (op)
            OP_ADD, OP_ADC:
            begin
                state_next.acc   = add_sum[7:0];
                state_next.flags = '{z: (add_sum[7:0] == 8'd0), n: 1'b0,
                                     h: add_half[4], c: add_sum[8]};
            end
            OP_ADD16:
            begin
                state_next.hl      = w_sum[15:0];
                state_next.flags.n = 1'b0;
                state_next.flags.h = w_half[12];
                state_next.flags.c = w_sum[16];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                if (op != OP_CP)
                    state_next.acc = sub_diff[7:0];
                state_next.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1,
                                     h: sub_half[4], c: sub_diff[8]};
            end
            OP_INC:
            begin
                rres = r + 8'd1;
                state_next.flags = '{z: (rres == 8'd0), n: 1'b0,
                                     h: (r[3:0] == 4'hF), c: cin};
            end
            OP_DEC:
            begin
                rres = r - 8'd1;
                state_next.flags = '{z: (rres == 8'd0), n: 1'b1,
                                     h: (r[3:0] == 4'h0), c: cin};
            end
            OP_AND:
            begin
                state_next.acc   = a & operand_byte;
                state_next.flags = '{z: ((a & operand_byte) == 8'd0), n: 1'b0,
                                     h: 1'b1, c: 1'b0};
            end
            OP_OR:
            begin
                state_next.acc   = a | operand_byte;
                state_next.flags = '{z: ((a | operand_byte) == 8'd0), n: 1'b0,
                                     h: 1'b0, c: 1'b0};
            end
            OP_XOR:
            begin
                state_next.acc   = a ^ operand_byte;
                state_next.flags = '{z: ((a ^ operand_byte) == 8'd0), n: 1'b0,
                                     h: 1'b0, c: 1'b0};
            end
            OP_SWAP:
            begin
                rres = {r[3:0], r[7:4]};
                state_next.flags = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            // Rotates always clear Z
            OP_RLC:
            begin
                rres = {r[6:0], r[7]};
                state_next.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: r[7]};
            end
            OP_RL:
            begin
                rres = {r[6:0], cin};
                state_next.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: r[7]};
            end
            OP_RRC:
            begin
                rres = {r[0], r[7:1]};
                state_next.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: r[0]};
            end
            OP_RR:
            begin
                rres = {cin, r[7:1]};
                state_next.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: r[0]};
            end
            OP_SLA:
            begin
                rres = {r[6:0], 1'b0};
                state_next.flags = '{z: (r[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: r[7]};
            end
            OP_SRA:
            begin
                rres = {r[7], r[7:1]};
                state_next.flags = '{z: (r[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: r[0]};
            end
            OP_SRL:
            begin
                rres = {1'b0, r[7:1]};
                state_next.flags = '{z: (r[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: r[0]};
            end
            OP_DAA:
            begin
                state_next.acc   = daa_res;
                state_next.flags = '{z: (daa_res == 8'd0), n: state.flags.n,
                                     h: 1'b0, c: daa_c};
            end
            default:
            begin
                // Unused codes leave the state alone
                state_next = state;
            end
        endcase
    end

    assign register_result = rres;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the 8-bit CPU ALU with accumulator, HL and flags.
module tb_top;
    import cpualu_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 60;
    localparam int RANDOM_PER_PHASE = 220;
    localparam int PRESSURE_ITEMS   = 30;
    localparam int TAIL_CYCLES      = 4;
    localparam int DECIMAL_CHAIN    = 6;

    // Opcode space the block does not decode
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd20;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 5'd31;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] operand_byte;
        logic [BYTE_W-1:0] reg_value;
        logic [WORD_W-1:0] operand_word;
    } alu_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] reg_result;
        logic [BYTE_W-1:0] acc;
        logic [WORD_W-1:0] hl;
        alu_flags_t        flags;
    } alu_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // operation, operand_byte, register_value, operand_word, zero pad
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // register_result, accumulator, hl_pair, flag_zero, flag_subtract,
    // flag_half, flag_carry, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow architectural state
    logic [BYTE_W-1:0] acc_q = '0;
    logic [WORD_W-1:0] hl_q = '0;
    alu_flags_t        flags_q = '0;

    alu_req_t    request_q[$];
    alu_result_t result_q[$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  hold_left = 0;
    logic req_fire = 1'b0;

    cpu_alu_with_flags u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // Execute one request against the shadow state and return what the block should show
    function automatic alu_result_t alu_exec(logic [OP_W-1:0] op, logic [BYTE_W-1:0] opnd,
                                             logic [BYTE_W-1:0] rv, logic [WORD_W-1:0] wv);
        logic [8:0]        sum9;
        logic [4:0]        nib5;
        logic [16:0]       sum17;
        logic [12:0]       sum13;
        logic [9:0]        adj;
        logic [BYTE_W-1:0] reg_out;
        logic              cin;
        logic              cin_eff;
        logic              c_new;
        alu_result_t       rs;
        cin = flags_q.c;
        reg_out = '0;
        case (op)
            OP_ADD, OP_ADC:
            begin
                cin_eff = (op == OP_ADC) ? cin : 1'b0;
                sum9 = {1'b0, acc_q} + {1'b0, opnd} + 9'(cin_eff);
                nib5 = {1'b0, acc_q[3:0]} + {1'b0, opnd[3:0]} + 5'(cin_eff);
                acc_q = sum9[7:0];
                flags_q = {sum9[7:0] == 8'h00, 1'b0, nib5[4], sum9[8]};
            end
            OP_ADD16:
            begin
                sum17 = {1'b0, hl_q} + {1'b0, wv};
                sum13 = {1'b0, hl_q[11:0]} + {1'b0, wv[11:0]};
                flags_q = {flags_q.z, 1'b0, sum13[12], sum17[16]};
                hl_q = sum17[15:0];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                // borrow shows up as the sign bit of the widened difference
                cin_eff = (op == OP_SBC) ? cin : 1'b0;
                sum9 = {1'b0, acc_q} - {1'b0, opnd} - 9'(cin_eff);
                nib5 = {1'b0, acc_q[3:0]} - {1'b0, opnd[3:0]} - 5'(cin_eff);
                if (op != OP_CP)
                    acc_q = sum9[7:0];
                flags_q = {sum9[7:0] == 8'h00, 1'b1, nib5[4], sum9[8]};
            end
            OP_INC:
            begin
                reg_out = rv + 8'd1;
                flags_q = {reg_out == 8'h00, 1'b0, rv[3:0] == 4'hF, cin};
            end
            OP_DEC:
            begin
                reg_out = rv - 8'd1;
                flags_q = {reg_out == 8'h00, 1'b1, rv[3:0] == 4'h0, cin};
            end
            OP_AND:
            begin
                acc_q = acc_q & opnd;
                flags_q = {acc_q == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_OR:
            begin
                acc_q = acc_q | opnd;
                flags_q = {acc_q == 8'h00, 3'b000};
            end
            OP_XOR:
            begin
                acc_q = acc_q ^ opnd;
                flags_q = {acc_q == 8'h00, 3'b000};
            end
            OP_SWAP:
            begin
                reg_out = {rv[3:0], rv[7:4]};
                flags_q = {reg_out == 8'h00, 3'b000};
            end
            OP_RLC:
            begin
                reg_out = {rv[6:0], rv[7]};
                flags_q = {3'b000, rv[7]};
            end
            OP_RL:
            begin
                reg_out = {rv[6:0], cin};
                flags_q = {3'b000, rv[7]};
            end
            OP_RRC:
            begin
                reg_out = {rv[0], rv[7:1]};
                flags_q = {3'b000, rv[0]};
            end
            OP_RR:
            begin
                reg_out = {cin, rv[7:1]};
                flags_q = {3'b000, rv[0]};
            end
            OP_SLA:
            begin
                reg_out = {rv[6:0], 1'b0};
                flags_q = {reg_out == 8'h00, 2'b00, rv[7]};
            end
            OP_SRA:
            begin
                reg_out = {rv[7], rv[7:1]};
                flags_q = {reg_out == 8'h00, 2'b00, rv[0]};
            end
            OP_SRL:
            begin
                reg_out = {1'b0, rv[7:1]};
                flags_q = {reg_out == 8'h00, 2'b00, rv[0]};
            end
            OP_DAA:
            begin
                adj = {2'b00, acc_q};
                c_new = cin;
                if (!flags_q.n)
                begin
                    if (cin || acc_q > DAA_HI_LIM)
                    begin
                        adj = adj + DAA_HI_ADJ;
                        c_new = 1'b1;
                    end
                    if (flags_q.h || acc_q[3:0] > DAA_LO_LIM)
                        adj = adj + DAA_LO_ADJ;
                end
                else
                begin
                    if (cin)
                        adj = adj - DAA_HI_ADJ;
                    if (flags_q.h)
                        adj = adj - DAA_LO_ADJ;
                end
                acc_q = adj[7:0];
                flags_q = {acc_q == 8'h00, flags_q.n, 1'b0, c_new};
            end
            default: ;  // undecoded code: state untouched
        endcase
        rs.reg_result = reg_out;
        rs.acc = acc_q;
        rs.hl = hl_q;
        rs.flags = flags_q;
        return rs;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sender: hold a request until taken, then maybe idle
    always @(negedge clk)
    begin : driver
        alu_req_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || req_fire)
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, it.operand_word, it.reg_value,
                            it.operand_byte, it.op};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done < holds_asked)
        begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check taken results first, then predict for the request taken this edge
    always @(posedge clk)
    begin : monitor
        alu_result_t want;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result 0x%0h arrived with no request pending", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("register_result", want.reg_result, m_tdata[7:0]);
                    check_field("accumulator", want.acc, m_tdata[15:8]);
                    check_field("hl_pair", want.hl, m_tdata[31:16]);
                    check_field("flag_zero", want.flags.z, m_tdata[32]);
                    check_field("flag_subtract", want.flags.n, m_tdata[33]);
                    check_field("flag_half", want.flags.h, m_tdata[34]);
                    check_field("flag_carry", want.flags.c, m_tdata[35]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                result_q.push_back(alu_exec(s_tdata[4:0], s_tdata[12:5], s_tdata[20:13],
                                            s_tdata[36:21]));
                items_taken++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] opnd,
                             logic [BYTE_W-1:0] rv, logic [WORD_W-1:0] wv);
        alu_req_t it;
        it.op = op;
        it.operand_byte = opnd;
        it.reg_value = rv;
        it.operand_word = wv;
        request_q.push_back(it);
        items_queued++;
    endtask

    function automatic logic [BYTE_W-1:0] bcd_byte();
        return {4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    function automatic logic [OP_W-1:0] decimal_arith_op();
        case ($urandom_range(3))
            0: return OP_ADD;
            1: return OP_ADC;
            2: return OP_SUB;
            default: return OP_SBC;
        endcase
    endfunction

    // Corner requests: wrap to zero, carry-in into half carry, 16-bit wrap,
    // half borrow on compare, decimal adjust both ways, register edges, bad codes
    task automatic queue_directed();
        push_item(OP_OR,    8'h01, 8'h00, 16'h0000);
        push_item(OP_ADD,   8'hFF, 8'h00, 16'h0000);
        push_item(OP_ADC,   8'h0F, 8'h00, 16'h0000);
        push_item(OP_ADD16, 8'h00, 8'h00, 16'hFFFF);
        push_item(OP_ADD16, 8'h00, 8'h00, 16'h0001);
        push_item(OP_SBC,   8'h00, 8'h00, 16'h0000);
        push_item(OP_SUB,   8'h0F, 8'h00, 16'h0000);
        push_item(OP_XOR,   8'h10, 8'h00, 16'h0000);
        push_item(OP_CP,    8'h01, 8'h00, 16'h0000);
        push_item(OP_AND,   8'h00, 8'h00, 16'h0000);
        push_item(OP_OR,    8'h99, 8'h00, 16'h0000);
        push_item(OP_ADD,   8'h01, 8'h00, 16'h0000);
        push_item(OP_DAA,   8'h00, 8'h00, 16'h0000);
        push_item(OP_SUB,   8'h01, 8'h00, 16'h0000);
        push_item(OP_DAA,   8'h00, 8'h00, 16'h0000);
        push_item(OP_INC,   8'h00, 8'hFF, 16'h0000);
        push_item(OP_DEC,   8'h00, 8'h00, 16'h0000);
        push_item(OP_SWAP,  8'h00, 8'hF0, 16'h0000);
        push_item(OP_RLC,   8'h00, 8'h80, 16'h0000);
        push_item(OP_RL,    8'h00, 8'h80, 16'h0000);
        push_item(OP_RRC,   8'h00, 8'h01, 16'h0000);
        push_item(OP_RR,    8'h00, 8'h01, 16'h0000);
        push_item(OP_SLA,   8'h00, 8'h80, 16'h0000);
        push_item(OP_SRA,   8'h00, 8'h81, 16'h0000);
        push_item(OP_SRL,   8'h00, 8'h01, 16'h0000);
        push_item(OP_UNUSED_HI, 8'hFF, 8'hFF, 16'hFFFF);
        push_item(OP_UNUSED_LO, 8'h00, 8'h00, 16'h0000);
    endtask

    // Mostly uniform operations, some decimal chains, a few undecoded codes
    task automatic queue_random(int n);
        int left;
        int pick;
        left = n;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 15 && left >= DECIMAL_CHAIN)
            begin
                push_item(OP_AND, 8'h00, 8'($urandom), 16'($urandom));
                push_item(OP_OR, bcd_byte(), 8'($urandom), 16'($urandom));
                push_item(decimal_arith_op(), bcd_byte(), 8'($urandom), 16'($urandom));
                push_item(OP_DAA, 8'($urandom), 8'($urandom), 16'($urandom));
                push_item(decimal_arith_op(), bcd_byte(), 8'($urandom), 16'($urandom));
                push_item(OP_DAA, 8'($urandom), 8'($urandom), 16'($urandom));
                left -= DECIMAL_CHAIN;
            end
            else
            begin
                if (pick < 22)
                    push_item(5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), 8'($urandom),
                              8'($urandom), 16'($urandom));
                else
                    push_item(5'($urandom_range(int'(OP_DAA))), 8'($urandom), 8'($urandom),
                              16'($urandom));
                left--;
            end
        end
    endtask

    // Sender pause: nothing new until every result is back
    task automatic wait_drained();
        while (items_taken != items_queued || result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random(n);
        wait_drained();
    endtask

    // Sequence of phases
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        wait_drained();

        run_phase(0, 0, RANDOM_PER_PHASE);
        run_phase(79, 0, RANDOM_PER_PHASE);
        run_phase(0, 79, RANDOM_PER_PHASE);
        run_phase(10, 10, RANDOM_PER_PHASE);

        // long receiver hold-off with a steady sender, so the input backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holds_asked++;
        queue_random(PRESSURE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cpualu_pkg.sv
rtl/core/cpualu_exec.sv
rtl/core/cpu_alu_with_flags.sv
verif/tb_top.sv
